// ===== design/expression_lexer_unit_macros.svh =====
`ifndef EXPRESSION_LEXER_UNIT_MACROS_SVH
`define EXPRESSION_LEXER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the block clock and off during reset.
`define EXL_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lexer check failed");

// Next-cycle implication, sampled on the block clock and off during reset.
`define EXL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

// ===== design/exl_pkg.sv =====
`default_nettype none

package exl_pkg;

   localparam logic [31:0] MAX_EXPR_LEN = 32'd65535;
   localparam logic [15:0] POS_MAX = (MAX_EXPR_LEN < 32'd65535) ? MAX_EXPR_LEN[15:0] : 16'hFFFF;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef logic [3:0] kind_type;

   localparam kind_type KIND_NUMBER    = 4'd0;
   localparam kind_type KIND_IDENT     = 4'd1;
   localparam kind_type KIND_UNIT      = 4'd2;
   localparam kind_type KIND_PLUS      = 4'd3;
   localparam kind_type KIND_MINUS     = 4'd4;
   localparam kind_type KIND_STAR      = 4'd5;
   localparam kind_type KIND_SLASH     = 4'd6;
   localparam kind_type KIND_PERCENT   = 4'd7;
   localparam kind_type KIND_CARET     = 4'd8;
   localparam kind_type KIND_LPAREN    = 4'd9;
   localparam kind_type KIND_RPAREN    = 4'd10;
   localparam kind_type KIND_COMMA     = 4'd11;
   localparam kind_type KIND_EQUAL     = 4'd12;
   localparam kind_type KIND_END_OK    = 4'd13;
   localparam kind_type KIND_EMPTY     = 4'd14;
   localparam kind_type KIND_DOT_ERROR = 4'd15;

   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_C      = 8'h63;
   localparam logic [7:0] CH_D      = 8'h64;
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_G      = 8'h67;
   localparam logic [7:0] CH_K      = 8'h6B;
   localparam logic [7:0] CH_M      = 8'h6D;
   localparam logic [7:0] CH_R      = 8'h72;

   // Word heads are packed with the first character in the low byte.
   localparam logic [23:0] UNIT_M   = {16'h0000, CH_M};
   localparam logic [23:0] UNIT_MM  = {8'h00, CH_M, CH_M};
   localparam logic [23:0] UNIT_CM  = {8'h00, CH_M, CH_C};
   localparam logic [23:0] UNIT_KM  = {8'h00, CH_M, CH_K};
   localparam logic [23:0] UNIT_RAD = {CH_D, CH_A, CH_R};
   localparam logic [23:0] UNIT_DEG = {CH_G, CH_E, CH_D};

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_WORD,
      MODE_NUMBER,
      MODE_DROP
   } mode_type;

   typedef struct packed {
      logic zero;
      logic hex;
      logic bin;
      logic dot;
      logic expo;
   } number_flags_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start_pos;
      logic [15:0] tok_len;
      logic        last;
   } result_type;

   // Results made by one character; first is always delivered before second.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_xdigit(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
             (c == CH_PCT) || (c == CH_CARET) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
             (c == CH_COMMA) || (c == CH_EQUAL);
   endfunction

   function automatic kind_type op_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_SLASH:  k = KIND_SLASH;
         CH_PCT:    k = KIND_PERCENT;
         CH_CARET:  k = KIND_CARET;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         CH_EQUAL:  k = KIND_EQUAL;
         default:   k = KIND_NUMBER;
      endcase
      return k;
   endfunction

   function automatic logic word_is_unit(input logic [15:0] len, input logic [23:0] head);
      logic unit;
      unit = 1'b0;
      if (len == 16'd1) begin
         unit = (head == UNIT_M);
      end else if (len == 16'd2) begin
         unit = (head == UNIT_MM) || (head == UNIT_CM) || (head == UNIT_KM);
      end else if (len == 16'd3) begin
         unit = (head == UNIT_RAD) || (head == UNIT_DEG);
      end
      return unit;
   endfunction

   // A hex e/E also passes as an exponent mark, and a 0b literal takes any decimal digit.
   function automatic logic number_accepts(input number_flags_type f, input logic [7:0] c);
      logic ok;
      ok = is_digit(c);
      if (f.zero && ((c == CH_LOW_X) || (c == CH_LOW_B))) ok = 1'b1;
      if (f.bin && ((c == CH_ZERO) || (c == CH_ONE))) ok = 1'b1;
      if (f.hex && is_xdigit(c)) ok = 1'b1;
      if (!f.expo) begin
         if ((c == CH_LOW_E) || (c == CH_UP_E)) ok = 1'b1;
         if (!f.dot && (c == CH_DOT)) ok = 1'b1;
      end
      if (f.expo && ((c == CH_MINUS) || (c == CH_PLUS))) ok = 1'b1;
      return ok;
   endfunction

endpackage

`default_nettype wire

// ===== design/exl_if.sv =====
`default_nettype none

interface exl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface exl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [15:0] start_pos;
   logic [15:0] tok_len;
   logic        last;

   modport source (output valid, output kind, output start_pos, output tok_len, output last,
                   input ready);
   modport sink (input valid, input kind, input start_pos, input tok_len, input last,
                 output ready);
endinterface

`default_nettype wire

// ===== design/exl_core.sv =====
`default_nettype none
`include "expression_lexer_unit_macros.svh"

module exl_core (
   input  logic              clock,
   input  logic              reset,
   exl_req_if.sink           req,
   input  logic              room,
   output exl_pkg::push_type push
);

   logic                      in_valid_ff;
   logic [7:0]                in_ch_ff;
   exl_pkg::mode_type         mode_ff, mode_in;
   logic [15:0]               position_ff, position_in;
   logic [15:0]               token_start_ff, token_start_in;
   logic [15:0]               token_length_ff, token_length_in;
   logic [23:0]               word_head_ff, word_head_in;
   exl_pkg::number_flags_type flags_ff, flags_in;
   logic                      any_token_ff, any_token_in;

   logic                      advance;
   logic [7:0]                c;
   logic [15:0]               pos;
   logic [15:0]               grown_len;
   logic                      word_char;
   logic                      handled;
   logic                      pend_valid;
   logic                      sec_valid;
   exl_pkg::result_type       pend_res;
   exl_pkg::result_type       sec_res;

   assign advance   = in_valid_ff && room;
   assign req.ready = !in_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         in_ch_ff <= req.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= exl_pkg::MODE_NORMAL;
         position_ff     <= '0;
         token_start_ff  <= '0;
         token_length_ff <= '0;
         word_head_ff    <= '0;
         flags_ff        <= '0;
         any_token_ff    <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         position_ff     <= position_in;
         token_start_ff  <= token_start_in;
         token_length_ff <= token_length_in;
         word_head_ff    <= word_head_in;
         flags_ff        <= flags_in;
         any_token_ff    <= any_token_in;
      end
   end

   assign c         = in_ch_ff;
   assign pos       = (position_ff < exl_pkg::POS_MAX) ? position_ff + 16'd1 : exl_pkg::POS_MAX;
   assign grown_len = (token_length_ff < exl_pkg::LEN_MAX) ? token_length_ff + 16'd1
                                                           : token_length_ff;
   assign word_char = exl_pkg::is_alpha(c) || exl_pkg::is_digit(c) || (c == exl_pkg::CH_UNDER);

   always_comb begin
      mode_in         = mode_ff;
      position_in     = position_ff;
      token_start_in  = token_start_ff;
      token_length_in = token_length_ff;
      word_head_in    = word_head_ff;
      flags_in        = flags_ff;
      any_token_in    = any_token_ff;
      handled         = 1'b0;
      pend_valid      = 1'b0;
      sec_valid       = 1'b0;
      sec_res         = '{kind: exl_pkg::KIND_END_OK, start_pos: 16'd0, tok_len: 16'd0,
                          last: 1'b1};

      if (advance) begin
         position_in = pos;
         if (c == exl_pkg::CH_END) begin
            if (mode_ff != exl_pkg::MODE_DROP) begin
               pend_valid   = (mode_ff == exl_pkg::MODE_WORD) || (mode_ff == exl_pkg::MODE_NUMBER);
               sec_valid    = 1'b1;
               sec_res.kind = (any_token_ff || pend_valid) ? exl_pkg::KIND_END_OK
                                                           : exl_pkg::KIND_EMPTY;
            end
            mode_in         = exl_pkg::MODE_NORMAL;
            position_in     = '0;
            token_start_in  = '0;
            token_length_in = '0;
            word_head_in    = '0;
            flags_in        = '0;
            any_token_in    = 1'b0;
         end else if (mode_ff != exl_pkg::MODE_DROP) begin
            unique case (mode_ff)
               exl_pkg::MODE_WORD: begin
                  if (word_char) begin
                     if (token_length_ff < 16'd3) begin
                        word_head_in = word_head_ff |
                                       ({16'h0000, c} << {token_length_ff[1:0], 3'b000});
                     end
                     token_length_in = grown_len;
                     handled         = 1'b1;
                  end else begin
                     pend_valid = 1'b1;
                  end
               end
               exl_pkg::MODE_NUMBER: begin
                  if (exl_pkg::number_accepts(flags_ff, c)) begin
                     if (flags_ff.zero && (c == exl_pkg::CH_LOW_X)) flags_in.hex = 1'b1;
                     if (flags_ff.zero && (c == exl_pkg::CH_LOW_B)) flags_in.bin = 1'b1;
                     flags_in.zero = 1'b0;
                     if ((c == exl_pkg::CH_LOW_E) || (c == exl_pkg::CH_UP_E)) begin
                        flags_in.expo = 1'b1;
                     end
                     if (c == exl_pkg::CH_DOT) flags_in.dot = 1'b1;
                     token_length_in = grown_len;
                     handled         = 1'b1;
                  end else if (c == exl_pkg::CH_DOT) begin
                     sec_valid         = 1'b1;
                     sec_res.kind      = exl_pkg::KIND_DOT_ERROR;
                     sec_res.start_pos = pos;
                     mode_in           = exl_pkg::MODE_DROP;
                     handled           = 1'b1;
                  end else begin
                     pend_valid = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            // The character that closed a word or number is looked at again here.
            if (!handled) begin
               mode_in      = exl_pkg::MODE_NORMAL;
               any_token_in = any_token_ff || pend_valid;
               if (exl_pkg::is_op(c)) begin
                  sec_valid         = 1'b1;
                  sec_res.kind      = exl_pkg::op_kind(c);
                  sec_res.start_pos = pos;
                  sec_res.tok_len   = 16'd1;
                  any_token_in      = 1'b1;
               end else if (exl_pkg::is_alpha(c) || (c == exl_pkg::CH_UNDER)) begin
                  mode_in         = exl_pkg::MODE_WORD;
                  token_start_in  = pos;
                  token_length_in = 16'd1;
                  word_head_in    = {16'h0000, c};
               end else if (exl_pkg::is_digit(c)) begin
                  mode_in         = exl_pkg::MODE_NUMBER;
                  token_start_in  = pos;
                  token_length_in = 16'd1;
                  flags_in        = '0;
                  flags_in.zero   = (c == exl_pkg::CH_ZERO);
               end
            end
         end
      end
   end

   always_comb begin
      pend_res.kind      = exl_pkg::KIND_NUMBER;
      if (mode_ff == exl_pkg::MODE_WORD) begin
         pend_res.kind = exl_pkg::word_is_unit(token_length_ff, word_head_ff) ?
                         exl_pkg::KIND_UNIT : exl_pkg::KIND_IDENT;
      end
      pend_res.start_pos = token_start_ff;
      pend_res.tok_len   = token_length_ff;
      pend_res.last      = !sec_valid;

      push.count  = {1'b0, pend_valid} + {1'b0, sec_valid};
      push.first  = pend_valid ? pend_res : sec_res;
      push.second = sec_res;
   end

   `EXL_ASSERT_IMPLIES(a_drop_is_silent, advance && mode_ff == exl_pkg::MODE_DROP && in_ch_ff != exl_pkg::CH_END, push.count == 2'd0)
   `EXL_ASSERT_IMPLIES(a_pair_marks_last, push.count == 2'd2, push.second.last && !push.first.last)
   `EXL_ASSERT_NEXT(a_end_clears_state, advance && in_ch_ff == exl_pkg::CH_END, position_ff == 16'd0 && mode_ff == exl_pkg::MODE_NORMAL)

endmodule

`default_nettype wire

// ===== design/exl_queue.sv =====
`default_nettype none
`include "expression_lexer_unit_macros.svh"

module exl_queue (
   input  logic              clock,
   input  logic              reset,
   input  exl_pkg::push_type push,
   output logic              room,
   exl_rsp_if.source         rsp
);

   exl_pkg::result_type entry_ff [4];
   logic [1:0]          wr_ptr_ff;
   logic [1:0]          rd_ptr_ff;
   logic [2:0]          count_ff, count_in;
   logic                pop;

   // Two free entries are needed since one character can make two results.
   assign room = (count_ff <= 3'd2);
   assign pop  = (count_ff != 3'd0) && rsp.ready;

   assign count_in = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push.count;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   assign rsp.valid     = (count_ff != 3'd0);
   assign rsp.kind      = entry_ff[rd_ptr_ff].kind;
   assign rsp.start_pos = entry_ff[rd_ptr_ff].start_pos;
   assign rsp.tok_len   = entry_ff[rd_ptr_ff].tok_len;
   assign rsp.last      = entry_ff[rd_ptr_ff].last;

   `EXL_ASSERT_IMPLIES(a_push_has_room, push.count != 2'd0, count_ff <= 3'd2)
   `EXL_ASSERT_IMPLIES(a_count_bound, 1'b1, count_ff <= 3'd4)
   `EXL_ASSERT_NEXT(a_pop_drains, rsp.valid && rsp.ready && push.count == 2'd0, count_ff == $past(count_ff) - 3'd1)

endmodule

`default_nettype wire

// ===== design/expression_lexer_unit.sv =====
// Streaming lexer for arithmetic expressions. Each request item carries one ASCII
// character, and a zero character ends the expression. Each response item is one token
// (kind, 1-based start position, length) or an end marker; the last response caused by a
// character has last set. A character that closes a word or number is lexed again in the
// same step, so one character can give two response items. The block takes one character
// per clock cycle while the request side does not stall: the character is registered,
// lexed once the queue has room, and its results are written into a four-entry result
// queue whose head drives the response channel. The request side stalls only while the
// queue has fewer than two free entries, which happens when the response side is held
// off or a character produces two results. After a dot that a number cannot take (a
// second point, or one after an exponent), an error item is sent and every character
// up to the expression end is consumed with no response, including the closing zero.
`default_nettype none

module expression_lexer_unit (
   input  logic      clock,
   input  logic      reset,
   exl_req_if.sink   req_if,
   exl_rsp_if.source rsp_if
);

   // Queue room, computed from the queue fill level only, gates the lexing stage.
   logic              room;
   exl_pkg::push_type push;

   // Input register plus lexer state and token decode.
   exl_core u_core (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .room  (room),
      .push  (push)
   );

   // Result queue that decouples lexing from the response handshake.
   exl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire
